>>> rtl/core/htsc_pkg.sv
// Package for the heap tree subtree copy block.
// Holds the item kind codes and the input and result beat structs.
// Depends on nothing; the top level imports it.
`default_nettype none

package htsc_pkg;

  localparam logic [2:0] KIND_LOAD_TGT = 3'd0;
  localparam logic [2:0] KIND_LOAD_SRC = 3'd1;
  localparam logic [2:0] KIND_OVERRIDE = 3'd2;
  localparam logic [2:0] KIND_EXTRACT  = 3'd3;
  localparam logic [2:0] KIND_READ_TGT = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] slot_index;
    logic [7:0] atom_value;
    logic [6:0] target_position;
    logic [6:0] source_position;
  } in_t;

  typedef struct packed {
    logic [7:0] read_atom;
    logic       copy_ok;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/core/htsc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; the address width follows from the depth.
// Depends on nothing.
`default_nettype none

module htsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/heap_tree_subtree_copy_top.sv
// Top level of the heap tree subtree copy block: control, walk stack and RAMs.
// Uses htsc_pkg for the beat structs and kind codes, and htsc_ram for storage.
// The source tree is held in two mirrored RAMs so both children read at once.
//
//   Channel  | Handshake              | Payload  | Beat taken when
//   ---------+------------------------+----------+-------------------------
//   input    | start / busy           | in_data  | start high, busy low
//   result   | out_valid (strobe)     | out_data | every cycle out_valid high
//
// Loads, unused kinds and out-of-range reads or overrides give their result straight from
// idle; an in-range read passes through a read state. An override walks the subtree in a
// visit-then-expand loop over the source RAMs, one node per pass, and stops early on an
// out-of-range target slot; an extract first runs a clearing sweep over the target.
// After reset a clearing pass zeroes both trees with busy held high. Reset is
// synchronous and active low.
// Results are strobed for one cycle; the receiver cannot stall them.
`default_nettype none

module heap_tree_subtree_copy_top
  import htsc_pkg::*;
#(
  parameter int TREE_SLOTS = 64,
  parameter int ATOM_WIDTH = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int AW    = $clog2(TREE_SLOTS);
  localparam int CW    = (AW + 2 > 8) ? AW + 2 : 8;
  localparam int SW    = AW + 2;
  localparam int STK_D = AW + 1;
  localparam int SIW   = $clog2(STK_D);
  localparam int SPW   = $clog2(STK_D + 1);

  localparam logic [CW-1:0]  SLOTS_CW = CW'(TREE_SLOTS);
  localparam logic [SW-1:0]  SLOTS_SW = SW'(TREE_SLOTS);
  localparam logic [15:0]    SLOTS_16 = 16'(TREE_SLOTS);
  localparam logic [AW-1:0]  LAST_A   = AW'(TREE_SLOTS - 1);
  localparam logic [SPW-1:0] DEPTH_SP = SPW'(STK_D);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_ROOT   = 6'b001000,
    S_VISIT  = 6'b010000,
    S_EXPAND = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic            clr_all_r, clr_all_nxt;
  logic [CW-1:0]   spos_r, spos_nxt;
  logic [CW-1:0]   cur_t_r, cur_t_nxt;
  logic [AW-1:0]   cur_s_r, cur_s_nxt;
  logic [SPW-1:0]  sp_r, sp_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_data_r, out_data_nxt;

  logic [CW-1:0]         stk_t_r [STK_D];
  logic [AW-1:0]         stk_s_r [STK_D];
  logic [ATOM_WIDTH-1:0] stk_v_r [STK_D];

  logic                  pw0_en, pw1_en;
  logic [SIW-1:0]        pw0_i, pw1_i;
  logic [CW-1:0]         pw0_t, pw1_t;
  logic [AW-1:0]         pw0_s, pw1_s;
  logic [ATOM_WIDTH-1:0] pw0_v, pw1_v;

  logic                  tgt_we;
  logic [AW-1:0]         tgt_waddr, tgt_raddr;
  logic [ATOM_WIDTH-1:0] tgt_wdata, tgt_rdata;
  logic                  src_we;
  logic [AW-1:0]         src_waddr, srca_raddr, srcb_raddr;
  logic [ATOM_WIDTH-1:0] src_wdata, srca_rdata, srcb_rdata;

  logic [15:0]           slot_x;
  logic [39:0]           atom_x;
  logic [39:0]           rd_x;
  logic                  slot_ok;
  logic [CW-1:0]         tpos_c, spos_c;
  logic [SPW-1:0]        sp_dec, sp_one;
  logic [SIW-1:0]        top_i;
  logic [SW-1:0]         top_sl, top_sr, cur_sl, cur_sr;
  logic [CW-1:0]         ct_l, ct_r;
  logic                  push_r, push_l;

  assign slot_x  = 16'(in_data.slot_index);
  assign atom_x  = 40'(in_data.atom_value);
  assign rd_x    = 40'(tgt_rdata);
  assign slot_ok = slot_x < SLOTS_16;
  assign tpos_c  = CW'(in_data.target_position);
  assign spos_c  = CW'(in_data.source_position);

  assign sp_dec = sp_r - SPW'(1);
  assign top_i  = sp_dec[SIW-1:0];
  assign top_sl = SW'({stk_s_r[top_i], 1'b1});
  assign top_sr = SW'({stk_s_r[top_i], 1'b0}) + SW'(2);
  assign cur_sl = SW'({cur_s_r, 1'b1});
  assign cur_sr = SW'({cur_s_r, 1'b0}) + SW'(2);
  assign ct_l   = {cur_t_r[CW-2:0], 1'b1};
  assign ct_r   = {cur_t_r[CW-2:0], 1'b0} + CW'(2);

  assign push_r = (cur_sr < SLOTS_SW) && (srcb_rdata != '0) && (sp_r < DEPTH_SP);
  assign sp_one = sp_r + SPW'(push_r);
  assign push_l = (cur_sl < SLOTS_SW) && (srca_rdata != '0) && (sp_one < DEPTH_SP);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_all_nxt   = clr_all_r;
    spos_nxt      = spos_r;
    cur_t_nxt     = cur_t_r;
    cur_s_nxt     = cur_s_r;
    sp_nxt        = sp_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;

    tgt_we     = 1'b0;
    tgt_waddr  = slot_x[AW-1:0];
    tgt_wdata  = atom_x[ATOM_WIDTH-1:0];
    tgt_raddr  = slot_x[AW-1:0];
    src_we     = 1'b0;
    src_waddr  = slot_x[AW-1:0];
    src_wdata  = atom_x[ATOM_WIDTH-1:0];
    srca_raddr = top_sl[AW-1:0];
    srcb_raddr = top_sr[AW-1:0];

    pw0_en = 1'b0;
    pw0_i  = sp_r[SIW-1:0];
    pw0_t  = ct_r;
    pw0_s  = cur_sr[AW-1:0];
    pw0_v  = srcb_rdata;
    pw1_en = 1'b0;
    pw1_i  = sp_one[SIW-1:0];
    pw1_t  = ct_l;
    pw1_s  = cur_sl[AW-1:0];
    pw1_v  = srca_rdata;

    unique case (state_r)
      S_CLEAR: begin
        tgt_we    = 1'b1;
        tgt_waddr = cnt_r;
        tgt_wdata = '0;
        src_we    = clr_all_r;
        src_waddr = cnt_r;
        src_wdata = '0;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == LAST_A) begin
          cnt_nxt = '0;
          if (clr_all_r) begin
            state_nxt = S_IDLE;
          end else if (spos_r >= SLOTS_CW) begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.copy_ok = 1'b1;
            state_nxt            = S_IDLE;
          end else begin
            srca_raddr = spos_r[AW-1:0];
            cur_t_nxt  = '0;
            cur_s_nxt  = spos_r[AW-1:0];
            state_nxt  = S_ROOT;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (in_data.kind)
            KIND_LOAD_TGT: begin
              tgt_we        = slot_ok;
              out_valid_nxt = 1'b1;
            end
            KIND_LOAD_SRC: begin
              src_we        = slot_ok;
              out_valid_nxt = 1'b1;
            end
            KIND_OVERRIDE: begin
              if (tpos_c >= SLOTS_CW) begin
                out_valid_nxt = 1'b1;
              end else if (spos_c >= SLOTS_CW) begin
                out_valid_nxt        = 1'b1;
                out_data_nxt.copy_ok = 1'b1;
              end else begin
                srca_raddr = spos_c[AW-1:0];
                cur_t_nxt  = tpos_c;
                cur_s_nxt  = spos_c[AW-1:0];
                state_nxt  = S_ROOT;
              end
            end
            KIND_EXTRACT: begin
              spos_nxt    = spos_c;
              clr_all_nxt = 1'b0;
              cnt_nxt     = '0;
              state_nxt   = S_CLEAR;
            end
            KIND_READ_TGT: begin
              if (slot_ok) begin
                state_nxt = S_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.read_atom = rd_x[7:0];
        state_nxt              = S_IDLE;
      end
      S_ROOT: begin
        pw0_en    = 1'b1;
        pw0_i     = '0;
        pw0_t     = cur_t_r;
        pw0_s     = cur_s_r;
        pw0_v     = srca_rdata;
        sp_nxt    = SPW'(1);
        state_nxt = S_VISIT;
      end
      S_VISIT: begin
        if (stk_t_r[top_i] >= SLOTS_CW) begin
          out_valid_nxt = 1'b1;
          sp_nxt        = '0;
          state_nxt     = S_IDLE;
        end else begin
          tgt_we    = 1'b1;
          tgt_waddr = stk_t_r[top_i][AW-1:0];
          tgt_wdata = stk_v_r[top_i];
          cur_t_nxt = stk_t_r[top_i];
          cur_s_nxt = stk_s_r[top_i];
          sp_nxt    = sp_dec;
          state_nxt = S_EXPAND;
        end
      end
      S_EXPAND: begin
        pw0_en = push_r;
        pw1_en = push_l;
        sp_nxt = sp_one + SPW'(push_l);
        if ((sp_one + SPW'(push_l)) == '0) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.copy_ok = 1'b1;
          state_nxt            = S_IDLE;
        end else begin
          state_nxt = S_VISIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_all_r   <= 1'b1;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_all_r   <= clr_all_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spos_r     <= spos_nxt;
    cur_t_r    <= cur_t_nxt;
    cur_s_r    <= cur_s_nxt;
    out_data_r <= out_data_nxt;
    if (pw0_en) begin
      stk_t_r[pw0_i] <= pw0_t;
      stk_s_r[pw0_i] <= pw0_s;
      stk_v_r[pw0_i] <= pw0_v;
    end
    if (pw1_en) begin
      stk_t_r[pw1_i] <= pw1_t;
      stk_s_r[pw1_i] <= pw1_s;
      stk_v_r[pw1_i] <= pw1_v;
    end
  end

  htsc_ram #(.WIDTH(ATOM_WIDTH), .DEPTH(TREE_SLOTS)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (tgt_waddr),
    .wdata (tgt_wdata),
    .raddr (tgt_raddr),
    .rdata (tgt_rdata)
  );

  htsc_ram #(.WIDTH(ATOM_WIDTH), .DEPTH(TREE_SLOTS)) u_srca_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (src_wdata),
    .raddr (srca_raddr),
    .rdata (srca_rdata)
  );

  htsc_ram #(.WIDTH(ATOM_WIDTH), .DEPTH(TREE_SLOTS)) u_srcb_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (src_wdata),
    .raddr (srcb_raddr),
    .rdata (srcb_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_visit_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VISIT) |-> (sp_r != '0))
    else $error("walk visit with an empty stack");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.kind == KIND_LOAD_TGT || in_data.kind == KIND_LOAD_SRC))
    |=> out_valid)
    else $error("load beat gave no result in the next cycle");

  a_read_data_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.read_atom != '0) |-> $past(state_r == S_READ))
    else $error("nonzero read atom outside a read item");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXPAND) |-> (sp_r < DEPTH_SP))
    else $error("walk stack pointer beyond its depth");
`endif

endmodule

`default_nettype wire

>>> verif/heap_tree_subtree_copy_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for heap_tree_subtree_copy_top: directed and random command beats.
// Keeps its own shadow of both trees to predict every result beat; depends on htsc_pkg.
module heap_tree_subtree_copy_top_test;
  import htsc_pkg::*;

  localparam int SLOTS = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BEATS = 700;

  class tree_copy_shadow;
    logic [7:0] tgt_atoms [SLOTS];
    logic [7:0] src_atoms [SLOTS];
    out_t pending_results [$];
    int unsigned errors;

    function new();
      foreach (tgt_atoms[i]) begin
        tgt_atoms[i] = '0;
        src_atoms[i] = '0;
      end
      errors = 0;
    endfunction

    function bit walk_copy(int unsigned troot, int unsigned sroot);
      int unsigned t_stack [$];
      int unsigned s_stack [$];
      int unsigned t, s;
      if (troot >= SLOTS) return 1'b0;
      if (sroot >= SLOTS) return 1'b1;
      t_stack.push_back(troot);
      s_stack.push_back(sroot);
      while (t_stack.size() > 0) begin
        t = t_stack.pop_back();
        s = s_stack.pop_back();
        if (t >= SLOTS) return 1'b0;
        tgt_atoms[t] = src_atoms[s];
        // Right is pushed first so that the left subtree is visited first.
        if (2 * s + 2 < SLOTS && src_atoms[2 * s + 2] != 0) begin
          t_stack.push_back(2 * t + 2);
          s_stack.push_back(2 * s + 2);
        end
        if (2 * s + 1 < SLOTS && src_atoms[2 * s + 1] != 0) begin
          t_stack.push_back(2 * t + 1);
          s_stack.push_back(2 * s + 1);
        end
      end
      return 1'b1;
    endfunction

    function void take_command(in_t cmd);
      out_t want;
      want = '0;
      case (cmd.kind)
        KIND_LOAD_TGT: tgt_atoms[cmd.slot_index] = cmd.atom_value;
        KIND_LOAD_SRC: src_atoms[cmd.slot_index] = cmd.atom_value;
        KIND_OVERRIDE: want.copy_ok = walk_copy(cmd.target_position, cmd.source_position);
        KIND_EXTRACT: begin
          foreach (tgt_atoms[i]) tgt_atoms[i] = '0;
          want.copy_ok = walk_copy(0, cmd.source_position);
        end
        KIND_READ_TGT: want.read_atom = tgt_atoms[cmd.slot_index];
        default: ;
      endcase
      pending_results.push_back(want);
    endfunction

    function void match_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        $error("Result beat arrived with no command outstanding.");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.read_atom !== want.read_atom) begin
        $error("read_atom: expected %0d, got %0d", want.read_atom, got.read_atom);
        errors++;
      end
      if (got.copy_ok !== want.copy_ok) begin
        $error("copy_ok: expected %0d, got %0d", want.copy_ok, got.copy_ok);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  tree_copy_shadow shadow = new();
  bit steady = 1'b0;
  int unsigned quiet_cycles = 0;

  heap_tree_subtree_copy_top #(
    .TREE_SLOTS(SLOTS),
    .ATOM_WIDTH(8)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) shadow.match_result(out_data);
      if (start && !busy) shadow.take_command(in_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("heap_tree_subtree_copy_top: mismatch");
        $finish;
      end
    end
  end

  function automatic in_t make_cmd(logic [2:0] kind, int unsigned slot, int unsigned atom,
                                   int unsigned tpos, int unsigned spos);
    in_t cmd;
    cmd.kind = kind;
    cmd.slot_index = slot[5:0];
    cmd.atom_value = atom[7:0];
    cmd.target_position = tpos[6:0];
    cmd.source_position = spos[6:0];
    return cmd;
  endfunction

  task automatic send_command(in_t cmd);
    if (!steady && $urandom_range(99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random();
    in_t cmd;
    logic [63:0] raw;
    int unsigned pick;
    raw = {$urandom, $urandom};
    cmd = raw[$bits(in_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 30) begin
      cmd.kind = KIND_LOAD_SRC;
      if ($urandom_range(9) == 0) cmd.atom_value = '0;
    end else if (pick < 42) begin
      cmd.kind = KIND_LOAD_TGT;
    end else if (pick < 62 || pick < 66) begin
      cmd.kind = (pick < 62) ? KIND_OVERRIDE : KIND_EXTRACT;
      if ($urandom_range(4) != 0) cmd.target_position = 7'($urandom_range(0, SLOTS - 1));
      if ($urandom_range(4) != 0) cmd.source_position = 7'($urandom_range(0, 15));
    end else if (pick < 94) begin
      cmd.kind = KIND_READ_TGT;
    end else begin
      cmd.kind = 3'($urandom_range(5, 7));
    end
    send_command(cmd);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Build a small source tree with an empty slot under the right child.
    send_command(make_cmd(KIND_LOAD_SRC, 0, 8'h11, 0, 0));
    send_command(make_cmd(KIND_LOAD_SRC, 1, 8'h22, 0, 0));
    send_command(make_cmd(KIND_LOAD_SRC, 2, 8'h33, 0, 0));
    send_command(make_cmd(KIND_LOAD_SRC, 3, 8'h44, 0, 0));
    send_command(make_cmd(KIND_LOAD_SRC, 6, 8'hff, 0, 0));
    send_command(make_cmd(KIND_LOAD_TGT, 63, 8'h80, 0, 0));
    send_command(make_cmd(KIND_READ_TGT, 63, 0, 0, 0));
    send_command(make_cmd(KIND_OVERRIDE, 0, 0, 0, 0));
    send_command(make_cmd(KIND_READ_TGT, 6, 0, 0, 0));
    // The subtree overflows the target part way through the walk.
    send_command(make_cmd(KIND_OVERRIDE, 0, 0, 40, 0));
    send_command(make_cmd(KIND_READ_TGT, 40, 0, 0, 0));
    send_command(make_cmd(KIND_OVERRIDE, 0, 0, 100, 0));
    send_command(make_cmd(KIND_OVERRIDE, 0, 0, 127, 127));
    send_command(make_cmd(KIND_OVERRIDE, 0, 0, 5, 70));
    send_command(make_cmd(KIND_OVERRIDE, 0, 0, 10, 5));
    send_command(make_cmd(KIND_READ_TGT, 10, 0, 0, 0));
    send_command(make_cmd(KIND_EXTRACT, 0, 0, 0, 1));
    send_command(make_cmd(KIND_READ_TGT, 1, 0, 0, 0));
    send_command(make_cmd(KIND_EXTRACT, 0, 0, 0, 127));
    send_command(make_cmd(KIND_READ_TGT, 0, 0, 0, 0));
    send_command(make_cmd(KIND_LOAD_TGT, 0, 8'hff, 127, 127));
    send_command(make_cmd(KIND_LOAD_SRC, 63, 8'hff, 127, 127));
    send_command(make_cmd(3'd5, 63, 8'hff, 127, 127));
    send_command(make_cmd(3'd7, 63, 8'hff, 127, 127));
    send_command(make_cmd(KIND_READ_TGT, 0, 0, 0, 0));

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      steady = (i >= 250 && i < 400);
      send_random();
    end
    start <= 1'b0;
    @(posedge clk);

    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
      $display("heap_tree_subtree_copy_top: match");
    end else begin
      $display("heap_tree_subtree_copy_top: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/htsc_pkg.sv
rtl/core/htsc_ram.sv
rtl/core/heap_tree_subtree_copy_top.sv
verif/heap_tree_subtree_copy_top_test.sv
